// File: src/lsd_pkg.sv
`default_nettype none
package lsd_pkg;

  // signature check window
  localparam int CHECK_LENGTH = 62;
  localparam int COUNT_W      = $clog2(CHECK_LENGTH + 1);
  localparam int SIG_POS_MID  = 30;
  localparam int SIG_POS_END  = 60;

  localparam logic [7:0] SIG_FIRST_BYTE = 8'h80;
  localparam logic [7:0] SIG_ZERO_BYTE  = 8'h00;

  localparam int DATA_W = 32;
  localparam int INDEX_W = 2;

  // register indexes of the configuration port
  typedef enum logic [INDEX_W-1:0] {
    REG_SEED    = 2'd0,
    REG_KEY_ONE = 2'd1,
    REG_KEY_TWO = 2'd2
  } reg_index_t;

  // seed reload constants
  localparam logic [31:0] SEED_LOW_XOR   = 32'h0000_1357;
  localparam logic [31:0] SEED_LOW_MASK  = 32'hffff_aaaa;
  localparam logic [31:0] SEED_HIGH_XOR  = 32'h4321_0000;
  localparam logic [31:0] SEED_HIGH_MASK = 32'habcd_ffff;
  localparam logic [31:0] HALF_LOW       = 32'h0000_ffff;
  localparam logic [31:0] HALF_HIGH      = 32'hffff_0000;

  typedef struct packed {
    logic                  we;
    logic [INDEX_W-1:0]    index;
    logic [DATA_W-1:0]     data;
  } cfg_write_t;

  typedef struct packed {
    logic done;
    logic ok;
  } check_t;

  typedef struct packed {
    logic [31:0] high;
    logic [31:0] low;
  } stream_t;

  function automatic stream_t reload_from_seed(input logic [31:0] seed);
    stream_t s;
    s.low  = ((~seed ^ SEED_LOW_XOR) << 16) | ((seed ^ SEED_LOW_MASK) & HALF_LOW);
    s.high = ((seed ^ SEED_HIGH_XOR) >> 16) | ((~seed ^ SEED_HIGH_MASK) & HALF_HIGH);
    return s;
  endfunction

  function automatic stream_t advance_stream(input stream_t cur,
                                             input logic [31:0] key_one,
                                             input logic [31:0] key_two);
    stream_t     s;
    logic [31:0] top;
    logic [31:0] t;
    top    = cur.low << 31;
    t      = ((cur.high >> 1) | top) ^ (key_one - 32'd1);
    t      = (t >> 1) | top;
    s.high = t ^ key_one;
    s.low  = ((cur.low >> 1) | (cur.high << 31)) ^ key_two;
    return s;
  endfunction

endpackage
`default_nettype wire

// File: src/login_stream_decrypt_unit.sv
`default_nettype none
// login stream decryptor with signature check
//
// input channel: in_valid / in_ready carry one request per received byte,
// cipher_byte plus start_req (reload keystream from seed before this byte)
// output channel: out_valid / out_ready carry plain_byte, check_done and
// check_ok for each request, in order, exactly one result per request
// configuration: cfg_we writes cfg_data to register cfg_index
// (0 seed, 1 key_one, 2 key_two, others ignored), write only while idle
//
// out_valid rises in the cycle after accept; one request per cycle while
// the receiver takes results, set by the keystream register pair which
// advances through combinational shift and xor logic
// the output register frees in_ready whenever it is empty or being taken,
// so a stalled receiver holds its result and holds off input only then
// reset: keystream halves and keys zero, byte count zero, signature good,
// output register empty; check_done comes with byte 61 after a start
module login_stream_decrypt_unit
  import lsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]  cfg_data,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         cipher_byte,
  input  wire logic               start_req,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              plain_byte,
  output logic                    check_done,
  output logic                    check_ok
);

  cfg_write_t cfg;
  logic       accept;
  logic [7:0] key_byte;
  logic [7:0] plain;
  check_t     check;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // output register empty or draining this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lsd_keystream u_keystream (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (accept),
    .start    (start_req),
    .key_byte (key_byte)
  );

  assign plain = cipher_byte ^ key_byte;

  lsd_check u_check (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .start  (start_req),
    .plain  (plain),
    .result (check)
  );

  // result register, control part
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // result register, payload part
  always_ff @(posedge clk) begin
    if (accept) begin
      plain_byte <= plain;
      check_done <= check.done;
      check_ok   <= check.ok;
    end
  end

  // a pass is only reported together with the end of the window
  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_ok |-> check_done)
    else $error("check_ok without check_done");

  // an accepted request always shows up as a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request did not produce a result");

  // the byte that carries a start is byte zero, never the end of a window
  a_start_not_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req |=> !check_done)
    else $error("check_done on a start byte");

endmodule
`default_nettype wire

// File: src/lsd_keystream.sv
`default_nettype none
module lsd_keystream
  import lsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_write_t cfg,
  input  wire logic       step,
  input  wire logic       start,
  output logic [7:0]      key_byte
);

  logic [31:0] seed;
  logic [31:0] key_one;
  logic [31:0] key_two;
  stream_t     stream;
  stream_t     stream_eff;
  stream_t     stream_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= '0;
      key_one <= '0;
      key_two <= '0;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_SEED:    seed    <= cfg.data;
        REG_KEY_ONE: key_one <= cfg.data;
        REG_KEY_TWO: key_two <= cfg.data;
        default:     ;
      endcase
    end
  end

  // a start request reloads before this byte is decrypted
  always_comb begin
    stream_eff  = start ? reload_from_seed(seed) : stream;
    stream_next = advance_stream(stream_eff, key_one, key_two);
    key_byte    = stream_eff.low[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream <= '0;
    end else if (step) begin
      stream <= stream_next;
    end
  end

endmodule
`default_nettype wire

// File: src/lsd_check.sv
`default_nettype none
module lsd_check
  import lsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic       start,
  input  wire logic [7:0] plain,
  output check_t          result
);

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic               signature_good;
  logic               signature_good_next;
  logic [COUNT_W-1:0] count_eff;
  logic               good_eff;

  always_comb begin
    count_eff           = start ? '0 : byte_count;
    good_eff            = start ? 1'b1 : signature_good;
    byte_count_next     = count_eff;
    signature_good_next = good_eff;
    result              = '0;
    if (count_eff < COUNT_W'(CHECK_LENGTH)) begin
      if (count_eff == '0 && plain != SIG_FIRST_BYTE) begin
        signature_good_next = 1'b0;
      end
      if ((count_eff == COUNT_W'(SIG_POS_MID) || count_eff == COUNT_W'(SIG_POS_END))
          && plain != SIG_ZERO_BYTE) begin
        signature_good_next = 1'b0;
      end
      if (count_eff == COUNT_W'(CHECK_LENGTH - 1)) begin
        result.done = 1'b1;
        result.ok   = signature_good_next;
      end
      byte_count_next = count_eff + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      signature_good <= 1'b1;
    end else if (step) begin
      byte_count     <= byte_count_next;
      signature_good <= signature_good_next;
    end
  end

endmodule
`default_nettype wire
